/* sv/suf_pkg.sv */
// ----------------------------------------------------------------------------
// suf_pkg
// shared types for the sphere union distance field block
// ----------------------------------------------------------------------------
package suf_pkg;

  localparam int unsigned CMD_LOAD  = 0;
  localparam int unsigned CMD_QUERY = 1;

  localparam int unsigned COUNT_W = 9;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned ROOT_W  = 17;
  localparam int unsigned REM_W   = 19;
  localparam int unsigned DIST_W  = 19;

  typedef struct packed {
    logic               command;
    logic [7:0]         atom_index;
    logic signed [15:0] atom_x;
    logic signed [15:0] atom_y;
    logic signed [15:0] atom_z;
    logic [9:0]         atom_radius;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [17:0] surface_distance;
    logic               no_atoms;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [9:0]         radius;
  } atom_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [9:0] radius;
  } ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0]  val;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

endpackage

/* sv/sphere_union_distance_field.sv */
// ----------------------------------------------------------------------------
// sphere_union_distance_field
// least distance from a grid point to a loaded set of spheres
// ----------------------------------------------------------------------------
// A load word writes one atom slot. A query word walks the first atom_count
// slots through an eight-stage pipeline (table read, difference, squares,
// sum, three square root stages, minimum), one atom per cycle from the
// single table read port while a held result is not stalled at the output;
// its result word is registered once the last atom reaches the minimum stage;
// the next word is taken once that result is captured. With atom_count zero
// the result is 0 with no_atoms set, in the cycle after the query.
module sphere_union_distance_field #(
  parameter int unsigned MAX_ATOMS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  suf_pkg::in_word_t        in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output suf_pkg::out_word_t       out_word,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [suf_pkg::COUNT_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);

  suf_pkg::atom_t atom_mem [MAX_ATOMS];

  logic [suf_pkg::COUNT_W-1:0] count_r;
  logic                        busy_r;
  logic                        issue_r;
  logic [AW-1:0]               idx_r;
  logic [CW-1:0]               n_r;
  logic [CW-1:0]               n_sat;
  logic signed [15:0]          px_r, py_r, pz_r;

  logic in_acc, load_acc, query_acc, en, final_hit;

  suf_pkg::ctl_t      c1_r, c2_r, c3_r, c4_r;
  suf_pkg::atom_t     rd_r;
  logic signed [16:0] dx_r, dy_r, dz_r;
  logic [31:0]        sx_r, sy_r, sz_r;
  logic [suf_pkg::SUM_W-1:0] sum_r;

  suf_pkg::ctl_t  c5, c6, c7;
  suf_pkg::sqrt_t q4, q5, q6, q7;

  logic signed [suf_pkg::DIST_W-1:0] d_cur, best_r, best_nxt;
  logic                              out_valid_r;
  suf_pkg::out_word_t                out_r;

  assign n_sat = (int'(count_r) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(count_r);

  assign in_stall  = busy_r | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign load_acc  = in_acc & (in_word.command == 1'(suf_pkg::CMD_LOAD));
  assign query_acc = in_acc & (in_word.command == 1'(suf_pkg::CMD_QUERY));
  assign cfg_ready = 1'b1;

  assign final_hit = c7.valid & c7.last;
  assign en        = ~(final_hit & out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_data;
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (load_acc && int'(in_word.atom_index) < MAX_ATOMS) begin
      atom_mem[AW'(in_word.atom_index)] <= '{x: in_word.atom_x, y: in_word.atom_y,
                                             z: in_word.atom_z,
                                             radius: in_word.atom_radius};
    end
    if (en) begin
      rd_r <= atom_mem[idx_r];
    end
  end

  // atom sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      if (query_acc && n_sat != '0) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        idx_r   <= '0;
        n_r     <= n_sat;
      end else if (en && issue_r) begin
        idx_r <= idx_r + 1'b1;
        if (CW'(idx_r) + 1'b1 == n_r) begin
          issue_r <= 1'b0;
        end
      end
      if (en && final_hit) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      px_r <= in_word.point_x;
      py_r <= in_word.point_y;
      pz_r <= in_word.point_z;
    end
  end

  // valid bits through the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
    end else if (en) begin
      c1_r.valid <= issue_r;
      c2_r.valid <= c1_r.valid;
      c3_r.valid <= c2_r.valid;
      c4_r.valid <= c3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r.first  <= (idx_r == '0);
      c1_r.last   <= (CW'(idx_r) + 1'b1 == n_r);
      c1_r.radius <= '0;

      c2_r.first  <= c1_r.first;
      c2_r.last   <= c1_r.last;
      c2_r.radius <= rd_r.radius;
      dx_r <= 17'(px_r) - 17'(rd_r.x);
      dy_r <= 17'(py_r) - 17'(rd_r.y);
      dz_r <= 17'(pz_r) - 17'(rd_r.z);

      c3_r.first  <= c2_r.first;
      c3_r.last   <= c2_r.last;
      c3_r.radius <= c2_r.radius;
      sx_r <= 32'(dx_r * dx_r);
      sy_r <= 32'(dy_r * dy_r);
      sz_r <= 32'(dz_r * dz_r);

      c4_r.first  <= c3_r.first;
      c4_r.last   <= c3_r.last;
      c4_r.radius <= c3_r.radius;
      sum_r <= suf_pkg::SUM_W'(sx_r) + suf_pkg::SUM_W'(sy_r) + suf_pkg::SUM_W'(sz_r);
    end
  end

  assign q4 = '{val: sum_r, rem: '0, root: '0};

  suf_sqrt_stage #(.STEPS(6)) u_sqrt0 (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(c4_r), .sq_i(q4), .ctl_o(c5), .sq_o(q5)
  );
  suf_sqrt_stage #(.STEPS(6)) u_sqrt1 (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(c5), .sq_i(q5), .ctl_o(c6), .sq_o(q6)
  );
  suf_sqrt_stage #(.STEPS(5)) u_sqrt2 (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(c6), .sq_i(q6), .ctl_o(c7), .sq_o(q7)
  );

  // radius subtract and running minimum
  assign d_cur = $signed({2'b00, q7.root}) - $signed({9'd0, c7.radius});
  assign best_nxt = (c7.first || d_cur < best_r) ? d_cur : best_r;

  always_ff @(posedge clk) begin
    if (en && c7.valid) begin
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && final_hit) begin
      out_valid_r <= 1'b1;
    end else if (query_acc && n_sat == '0) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && final_hit) begin
      out_r.surface_distance <= 18'(best_nxt);
      out_r.no_atoms         <= 1'b0;
    end else if (query_acc && n_sat == '0) begin
      out_r.surface_distance <= '0;
      out_r.no_atoms         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* sv/suf_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// suf_sqrt_stage
// STEPS digit steps of the floored integer square root, registered
// ----------------------------------------------------------------------------
module suf_sqrt_stage #(
  parameter int unsigned STEPS = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  suf_pkg::ctl_t    ctl_i,
  input  suf_pkg::sqrt_t   sq_i,
  output suf_pkg::ctl_t    ctl_o,
  output suf_pkg::sqrt_t   sq_o
);

  suf_pkg::ctl_t  ctl_r;
  suf_pkg::sqrt_t sq_r;
  suf_pkg::sqrt_t sq_nxt;

  always_comb begin
    logic [suf_pkg::REM_W+1:0]  t;
    logic [suf_pkg::ROOT_W+1:0] trial;
    sq_nxt = sq_i;
    for (int s = 0; s < STEPS; s++) begin
      t          = {sq_nxt.rem, sq_nxt.val[suf_pkg::SUM_W-1 -: 2]};
      sq_nxt.val = {sq_nxt.val[suf_pkg::SUM_W-3:0], 2'b00};
      trial      = {sq_nxt.root, 2'b01};
      if (t >= (suf_pkg::REM_W+2)'(trial)) begin
        sq_nxt.rem  = suf_pkg::REM_W'(t - (suf_pkg::REM_W+2)'(trial));
        sq_nxt.root = {sq_nxt.root[suf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_nxt.rem  = suf_pkg::REM_W'(t);
        sq_nxt.root = {sq_nxt.root[suf_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.first  <= ctl_i.first;
      ctl_r.last   <= ctl_i.last;
      ctl_r.radius <= ctl_i.radius;
      sq_r         <= sq_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign sq_o  = sq_r;

endmodule
